// ----- rtl/core/kvfp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kvfp_pkg
// Shared constants, codes and types of the cache block frame parser.
// ----------------------------------------------------------------------------
package kvfp_pkg;

	localparam int COUNT_BITS   = 64;
	localparam int HDR_BYTES    = 52;
	localparam int HDR_BITS     = 8 * HDR_BYTES;
	localparam int HDR_IDX_BITS = $clog2(HDR_BYTES);
	localparam logic [31:0] MAGIC_WORD = 32'h424B_564D;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam int TDATA_BITS = 192;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_SHORT   = 3'd1;
	localparam status_t ST_TOTAL   = 3'd2;
	localparam status_t ST_MAGIC   = 3'd3;
	localparam status_t ST_VERSION = 3'd4;
	localparam status_t ST_PAYLOAD = 3'd5;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_KEY    = 2'd0;
	localparam kind_t KIND_VALUE  = 2'd1;
	localparam kind_t KIND_STATUS = 2'd2;

	typedef struct packed {
		logic [63:0] total;
		logic [31:0] magic;
		logic [15:0] version;
		logic [15:0] dtype;
		logic [63:0] hash;
		logic [31:0] layer;
		logic [31:0] tokens;
		logic [15:0] heads;
		logic [15:0] hd_width;
		logic [63:0] key_len;
		logic [63:0] value_len;
	} hdr_fields_t;

	typedef struct packed {
		logic        has_payload;
		logic        value_kind;
		logic [7:0]  payload_byte;
		logic        has_status;
		status_t     status_code;
		logic [15:0] element_type;
		logic [63:0] block_hash;
		logic [31:0] layer_index;
		logic [31:0] token_count;
		logic [15:0] head_count;
		logic [15:0] head_width;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic hdr_fields_t hdr_unpack(input logic [HDR_BITS-1:0] h);
		hdr_fields_t f;
		f.total     = h[0   +: 64];
		f.magic     = h[64  +: 32];
		f.version   = h[96  +: 16];
		f.dtype     = h[112 +: 16];
		f.hash      = h[128 +: 64];
		f.layer     = h[192 +: 32];
		f.tokens    = h[224 +: 32];
		f.heads     = h[256 +: 16];
		f.hd_width  = h[272 +: 16];
		f.key_len   = h[288 +: 64];
		f.value_len = h[352 +: 64];
		return f;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/kvfp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kvfp_front
// Accepts bytes, captures the header, tags payload and checks the block.
// ----------------------------------------------------------------------------
module kvfp_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [7:0]          in_byte,
	input  wire logic                in_last,
	input  wire logic [15:0]         version_ref,
	input  wire kvfp_pkg::qstat_t    qstat,
	output logic                     push,
	output kvfp_pkg::entry_t         entry
);

	localparam logic [kvfp_pkg::COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [kvfp_pkg::COUNT_BITS-1:0] CNT_HDR =
		kvfp_pkg::COUNT_BITS'(kvfp_pkg::HDR_BYTES);
	localparam logic [65:0] SUM_HDR = 66'(kvfp_pkg::HDR_BYTES);

	logic [kvfp_pkg::COUNT_BITS-1:0] off_q;
	logic [kvfp_pkg::COUNT_BITS-1:0] len;
	logic [kvfp_pkg::HDR_BITS-1:0]   hdr_q;
	logic [kvfp_pkg::HDR_BITS-1:0]   hdr_d;
	kvfp_pkg::hdr_fields_t           live;
	logic                            en;
	logic                            accept;
	logic                            in_hdr;
	logic [63:0]                     pay_off;

	logic                            valid_s1;
	logic                            pay_s1;
	logic                            kind_s1;
	logic [7:0]                      byte_s1;
	logic                            last_s1;
	logic [kvfp_pkg::COUNT_BITS-1:0] len_s1;
	kvfp_pkg::hdr_fields_t           fld_s1;

	logic                            valid_s2;
	logic                            pay_s2;
	logic                            kind_s2;
	logic [7:0]                      byte_s2;
	logic                            last_s2;
	logic [63:0]                     len_s2;
	kvfp_pkg::hdr_fields_t           fld_s2;
	logic                            short_s2;
	logic                            total_s2;
	logic                            magic_s2;
	logic                            version_s2;
	logic [64:0]                     sum_s2;

	logic [65:0]                     tot;
	logic                            pay_fail;
	kvfp_pkg::status_t               status;

	assign en       = !(valid_s2 && qstat.full);
	assign in_ready = en;
	assign accept   = in_valid && en;
	assign in_hdr   = off_q < CNT_HDR;
	assign len      = (off_q == CNT_MAX) ? off_q : off_q + kvfp_pkg::COUNT_BITS'(1);
	assign live     = kvfp_pkg::hdr_unpack(hdr_q);
	assign pay_off  = 64'(off_q - CNT_HDR);

	always_comb begin
		hdr_d = hdr_q;
		if (in_hdr) begin
			hdr_d[{off_q[kvfp_pkg::HDR_IDX_BITS-1:0], 3'b000} +: 8] = in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q    <= '0;
			hdr_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				if (in_last) begin
					off_q <= '0;
					hdr_q <= '0;
				end else begin
					off_q <= len;
					hdr_q <= hdr_d;
				end
			end
			if (en) begin
				valid_s1 <= accept && (!in_hdr || in_last);
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1     <= !in_hdr;
			kind_s1    <= !(pay_off < live.key_len);
			byte_s1    <= in_byte;
			last_s1    <= in_last;
			len_s1     <= len;
			fld_s1     <= kvfp_pkg::hdr_unpack(hdr_d);

			pay_s2     <= pay_s1;
			kind_s2    <= kind_s1;
			byte_s2    <= byte_s1;
			last_s2    <= last_s1;
			len_s2     <= 64'(len_s1);
			fld_s2     <= fld_s1;
			short_s2   <= len_s1 < CNT_HDR;
			total_s2   <= fld_s1.total != 64'(len_s1);
			magic_s2   <= fld_s1.magic != kvfp_pkg::MAGIC_WORD;
			version_s2 <= fld_s1.version != version_ref;
			sum_s2     <= {1'b0, fld_s1.key_len} + {1'b0, fld_s1.value_len};
		end
	end

	assign tot      = {1'b0, sum_s2} + SUM_HDR;
	assign pay_fail = (tot[65:64] != 2'b00) || (tot[63:0] != len_s2);

	always_comb begin
		if (short_s2) begin
			status = kvfp_pkg::ST_SHORT;
		end else if (total_s2) begin
			status = kvfp_pkg::ST_TOTAL;
		end else if (magic_s2) begin
			status = kvfp_pkg::ST_MAGIC;
		end else if (version_s2) begin
			status = kvfp_pkg::ST_VERSION;
		end else if (pay_fail) begin
			status = kvfp_pkg::ST_PAYLOAD;
		end else begin
			status = kvfp_pkg::ST_OK;
		end
	end

	assign push = valid_s2 && en;

	always_comb begin
		entry.has_payload  = pay_s2;
		entry.value_kind   = kind_s2;
		entry.payload_byte = byte_s2;
		entry.has_status   = last_s2;
		entry.status_code  = status;
		entry.element_type = fld_s2.dtype;
		entry.block_hash   = fld_s2.hash;
		entry.layer_index  = fld_s2.layer;
		entry.token_count  = fld_s2.tokens;
		entry.head_count   = fld_s2.heads;
		entry.head_width   = fld_s2.hd_width;
	end

endmodule
`default_nettype wire

// ----- rtl/core/kvfp_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kvfp_queue
// Short FIFO between the parsing front and the output back end.
// ----------------------------------------------------------------------------
module kvfp_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire kvfp_pkg::entry_t  wr_entry,
	input  wire logic              pop,
	output kvfp_pkg::entry_t       rd_entry,
	output kvfp_pkg::qstat_t       qstat
);

	kvfp_pkg::entry_t                  mem [kvfp_pkg::QUEUE_DEPTH];
	logic [kvfp_pkg::QPTR_BITS-1:0]    wr_ptr_q;
	logic [kvfp_pkg::QPTR_BITS-1:0]    rd_ptr_q;
	logic [kvfp_pkg::QCNT_BITS-1:0]    cnt_q;

	assign qstat.full  = cnt_q == kvfp_pkg::QCNT_BITS'(kvfp_pkg::QUEUE_DEPTH);
	assign qstat.empty = cnt_q == '0;
	assign rd_entry    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + kvfp_pkg::QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + kvfp_pkg::QPTR_BITS'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + kvfp_pkg::QCNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - kvfp_pkg::QCNT_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/kvfp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kvfp_back
// Expands queued entries into payload and status items on the output register.
// ----------------------------------------------------------------------------
module kvfp_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire kvfp_pkg::qstat_t              qstat,
	input  wire kvfp_pkg::entry_t              head,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [kvfp_pkg::TDATA_BITS-1:0]    out_tdata,
	output kvfp_pkg::kind_t                    out_tuser,
	output logic                               out_tlast
);

	logic out_valid_q;
	logic phase_q;
	logic load;
	logic have;
	logic emit_payload;

	assign load         = !out_valid_q || out_ready;
	assign have         = !qstat.empty;
	assign emit_payload = head.has_payload && !phase_q;
	assign pop          = load && have && !(emit_payload && head.has_status);
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= have;
			if (have) begin
				phase_q <= emit_payload && head.has_status;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && have) begin
			if (emit_payload) begin
				out_tuser <= head.value_kind ? kvfp_pkg::KIND_VALUE : kvfp_pkg::KIND_KEY;
				out_tdata <= kvfp_pkg::TDATA_BITS'(head.payload_byte);
				out_tlast <= 1'b0;
			end else begin
				out_tuser <= kvfp_pkg::KIND_STATUS;
				out_tdata <= {5'b0, head.head_width, head.head_count, head.token_count,
					head.layer_index, head.block_hash, head.element_type,
					head.status_code, 8'h00};
				out_tlast <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/kv_block_frame_parser_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kv_block_frame_parser_core
// Streaming parser for serialized key/value cache blocks with header checks.
// ----------------------------------------------------------------------------
// An item passes the check stages s1 and s2, the queue and the output register
// before it is valid. Throughput: one byte per cycle while the queue is not full;
// the last byte of a block that carries payload yields two output items.
// The check pipeline (two stages) and a four-entry queue sit before the
// output register; the queue absorbs output stalls.
// Reset clears the byte counter, captured header and queue; version is 1.
module kv_block_frame_parser_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [7:0]                         s_axis_tdata,  // data_byte
	input  wire logic                               s_axis_tlast,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// payload_byte, status_code, element_type, block_hash, layer_index,
	// token_count, head_count, head_width, zero fill
	output logic [kvfp_pkg::TDATA_BITS-1:0]         m_axis_tdata,
	output logic [1:0]                              m_axis_tuser,  // item_kind
	output logic                                    m_axis_tlast,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [15:0]                        cfg_data       // expected_version
);

	logic [15:0]       version_q;
	kvfp_pkg::qstat_t  qstat;
	kvfp_pkg::entry_t  wr_entry;
	kvfp_pkg::entry_t  head;
	logic              push;
	logic              pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= 16'd1;
		end else if (cfg_valid) begin
			version_q <= cfg_data;
		end
	end

	kvfp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.version_ref (version_q),
		.qstat       (qstat),
		.push        (push),
		.entry       (wr_entry)
	);

	kvfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (head),
		.qstat    (qstat)
	);

	kvfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_tdata (m_axis_tdata),
		.out_tuser (m_axis_tuser),
		.out_tlast (m_axis_tlast)
	);

endmodule
`default_nettype wire
